### rtl/sle_pkg.sv
`default_nettype none

package sle_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int OCNT_W  = 5;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WIDE_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request codes.
    localparam logic [1:0] REQ_SORT = 2'd0;
    localparam logic [1:0] REQ_POS  = 2'd1;
    localparam logic [1:0] REQ_DEL  = 2'd2;
    localparam logic [1:0] REQ_LIST = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS_SORT,
        CELL_INS_POS,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t                   op;
        logic signed [DATA_W-1:0]   value;
        logic [POS_W-1:0]           position;
        logic [CNT_W-1:0]           count;
    } sle_ctl_t;

endpackage

`default_nettype wire

### rtl/sle_cell.sv
`default_nettype none

module sle_cell (
    input  wire                                 clk,
    input  sle_pkg::sle_ctl_t                   ctl,
    input  wire  [sle_pkg::IDX_W-1:0]           idx,
    input  wire  signed [sle_pkg::DATA_W-1:0]   left_entry,
    input  wire  signed [sle_pkg::DATA_W-1:0]   right_entry,
    input  wire  signed [sle_pkg::DATA_W-1:0]   head_entry,
    input  wire                                 found_in,
    output logic                                found_out,
    output logic signed [sle_pkg::DATA_W-1:0]   entry
);
    import sle_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     occ;
    logic                     is_end;
    logic                     hit;

    always_comb
    begin
        occ    = CNT_W'(idx) < ctl.count;
        is_end = (CNT_W'(idx) + CNT_W'(1)) == ctl.count;
        hit    = 1'b0;
        case (ctl.op)
            CELL_INS_SORT: hit = !occ || !(entry_reg < ctl.value);
            CELL_INS_POS:  hit = !occ || (WIDE_W'(idx) >= WIDE_W'(ctl.position));
            CELL_DEL:      hit = occ && (entry_reg == ctl.value);
            default:       hit = 1'b0;
        endcase
        found_out = found_in || hit;
    end

    // Inserts shift the tail right, deletes shift it left, and a rotation
    // walks the occupied part one place toward the head.
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op) inside
            CELL_INS_SORT, CELL_INS_POS:
            begin
                if (found_in)
                    entry_next = left_entry;
                else if (hit)
                    entry_next = ctl.value;
            end
            CELL_DEL:
            begin
                if (found_in || hit)
                    entry_next = right_entry;
            end
            CELL_ROT:
            begin
                if (occ)
                    entry_next = is_end ? head_entry : right_entry;
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### rtl/sorted_list_engine_unit.sv
`default_nettype none

// Channel  Dir  Beat fields (tdata low bit up / tuser / tlast)
// -------  ---  -----------------------------------------------------------
// s_*      in   tdata: value[31:0], position[36:32], zero pad to 40 bits
//               tuser: req_type[1:0]
// m_*      out  tdata: entry_value[31:0], entry_count[36:32], zero pad
//               tuser: status[1:0]; tlast: last result of the request
//
// An insert or delete is done at the accepting edge, where every cell updates, and the
// next request is taken in the next cycle as long as the result beat leaves at that edge.
// A list request is accepted first, then one beat per entry leaves as the row rotates its
// occupied part past the head cell. Reset clears the count and the control
// state; the cells have no reset and need no clearing pass, since only entries below the
// count are ever read. A stalled output stops the rotation and keeps the input side closed.

module sorted_list_engine_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // value[31:0], position[36:32]
    input  wire  [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // entry_value[31:0], entry_count[36:32]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);
    import sle_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic                     state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         list_idx_reg, list_idx_next;

    logic                     m_valid_reg, m_valid_next;
    logic [1:0]               m_status_reg, m_status_next;
    logic signed [DATA_W-1:0] m_value_reg, m_value_next;
    logic [OCNT_W-1:0]        m_count_reg, m_count_next;
    logic                     m_last_reg, m_last_next;

    logic                     out_free;
    logic                     in_accept;
    logic                     full;
    logic                     empty;
    logic                     load;
    logic                     list_last;
    logic [1:0]               req;
    logic signed [DATA_W-1:0] in_value;
    logic [POS_W-1:0]         in_pos;

    sle_ctl_t                 ctl;
    logic signed [DATA_W-1:0] cell_entry [DEPTH];
    logic                     found_chain [DEPTH+1];

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;
    assign req       = s_tuser;
    assign in_value  = s_tdata[31:0];
    assign in_pos    = s_tdata[36:32];
    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign list_last = (CNT_W'(list_idx_reg) + CNT_W'(1)) == count_reg;

    // The row of cells. The found flag ripples from the head toward the
    // tail, so each cell knows whether the insert or delete point lies
    // ahead of it.
    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_e;
        logic signed [DATA_W-1:0] right_e;

        if (i == 0)
        begin : g_first
            assign left_e = '0;
        end
        else
        begin : g_mid_l
            assign left_e = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_mid_r
            assign right_e = cell_entry[i+1];
        end

        sle_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .idx         (IDX_W'(i)),
            .left_entry  (left_e),
            .right_entry (right_e),
            .head_entry  (cell_entry[0]),
            .found_in    (found_chain[i]),
            .found_out   (found_chain[i+1]),
            .entry       (cell_entry[i])
        );
    end

    // Command to the row. It never depends on the search result, so the
    // cells only move on a delete when a match exists.
    always_comb
    begin
        ctl.op       = CELL_HOLD;
        ctl.value    = in_value;
        ctl.position = in_pos;
        ctl.count    = count_reg;
        if (in_accept)
        begin
            unique case (req) inside
                REQ_SORT:
                begin
                    if (!full)
                        ctl.op = CELL_INS_SORT;
                end
                REQ_POS:
                begin
                    if (!full)
                        ctl.op = CELL_INS_POS;
                end
                REQ_DEL:
                begin
                    if (!empty)
                        ctl.op = CELL_DEL;
                end
                REQ_LIST: ctl.op = CELL_HOLD;
            endcase
        end
        else if ((state_reg == ST_LIST) && out_free)
        begin
            ctl.op = CELL_ROT;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        load          = 1'b0;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;

        if (in_accept)
        begin
            m_value_next = '0;
            m_last_next  = 1'b1;
            unique case (req) inside
                REQ_SORT, REQ_POS:
                begin
                    load = 1'b1;
                    if (full)
                    begin
                        m_status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next    = count_reg + CNT_W'(1);
                        m_status_next = ST_OK;
                    end
                end
                REQ_DEL:
                begin
                    load = 1'b1;
                    if (empty)
                    begin
                        m_status_next = ST_EMPTY;
                    end
                    else if (found_chain[DEPTH])
                    begin
                        count_next    = count_reg - CNT_W'(1);
                        m_status_next = ST_OK;
                    end
                    else
                    begin
                        m_status_next = ST_NOTFOUND;
                    end
                end
                REQ_LIST:
                begin
                    if (empty)
                    begin
                        load          = 1'b1;
                        m_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next    = ST_LIST;
                        list_idx_next = '0;
                    end
                end
            endcase
            m_count_next = OCNT_W'(count_next);
        end
        else if ((state_reg == ST_LIST) && out_free)
        begin
            // Emit the head and rotate it to the tail of the occupied part.
            load          = 1'b1;
            m_status_next = ST_OK;
            m_value_next  = cell_entry[0];
            m_count_next  = OCNT_W'(count_reg);
            m_last_next   = list_last;
            if (list_last)
            begin
                state_next    = ST_IDLE;
                list_idx_next = '0;
            end
            else
            begin
                list_idx_next = list_idx_reg + IDX_W'(1);
            end
        end

        if (load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_status_reg <= m_status_next;
            m_value_reg  <= m_value_next;
            m_count_reg  <= m_count_next;
            m_last_reg   <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_count_reg, m_value_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (count_reg != '0))
        else $error("list walk on an empty list");

    a_list_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (CNT_W'(list_idx_reg) < count_reg))
        else $error("list walk index past the count");

    a_list_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (req == REQ_LIST) && !empty) |=>
            ((state_reg == ST_LIST) && $stable(count_reg)))
        else $error("list request did not start a walk");
`endif

endmodule

`default_nettype wire

### bench/testbench.sv
`default_nettype none

// Self-checking bench for the sorted list engine. Requests go in as beats on
// the s_* side; every beat that leaves on the m_* side is compared with the
// oldest beat the list model predicts.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    // Cycles without any accepted beat before the run is declared hung. The
    // longest correct gap comes from the receiver hold-off.
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 370;
    localparam int DRAIN_CYCLES = 20;

    // One expected output beat.
    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] entry_value;
        logic [4:0]         entry_count;
        logic               last;
    } list_beat_t;

    // The scoreboard keeps its own copy of the list and queues the output
    // beats that each accepted request must produce.
    class list_scoreboard;
        logic signed [31:0] cells [DEPTH];
        int                 fill;
        list_beat_t         due [$];
        int                 errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void push_beat(logic [1:0] status, logic signed [31:0] val, logic last);
            list_beat_t b;
            b.status      = status;
            b.entry_value = val;
            b.entry_count = 5'(fill);
            b.last        = last;
            due.push_back(b);
        endfunction

        // Apply one accepted request to the list copy and queue its beats.
        function void note_request(logic [1:0] req, logic signed [31:0] val,
                                   logic [4:0] pos);
            int slot;
            int k;
            case (req) inside
                REQ_SORT, REQ_POS:
                begin
                    if (fill >= DEPTH)
                    begin
                        push_beat(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        if (req == REQ_SORT)
                        begin
                            // Goes in front of the first entry that is not
                            // smaller, so a new value lands ahead of equal ones.
                            slot = 0;
                            while (slot < fill && cells[slot] < val)
                                slot++;
                        end
                        else
                        begin
                            slot = (int'(pos) > fill) ? fill : int'(pos);
                        end
                        for (k = fill; k > slot; k--)
                            cells[k] = cells[k-1];
                        cells[slot] = val;
                        fill++;
                        push_beat(ST_OK, '0, 1'b1);
                    end
                end
                REQ_DEL:
                begin
                    if (fill == 0)
                    begin
                        push_beat(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        slot = 0;
                        while (slot < fill && cells[slot] != val)
                            slot++;
                        if (slot == fill)
                        begin
                            push_beat(ST_NOTFOUND, '0, 1'b1);
                        end
                        else
                        begin
                            for (k = slot; k + 1 < fill; k++)
                                cells[k] = cells[k+1];
                            fill--;
                            push_beat(ST_OK, '0, 1'b1);
                        end
                    end
                end
                default:
                begin
                    if (fill == 0)
                        push_beat(ST_EMPTY, '0, 1'b1);
                    else
                        for (k = 0; k < fill; k++)
                            push_beat(ST_OK, cells[k], k == fill - 1);
                end
            endcase
        endfunction

        task report(string what, logic [39:0] got, logic [39:0] want);
            $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
            errors++;
        endtask

        task check_beat(logic [1:0] status, logic [39:0] data, logic last);
            list_beat_t b;
            if (due.size() == 0)
            begin
                report("output beat with nothing pending", data, '0);
            end
            else
            begin
                b = due.pop_front();
                if (status != b.status)
                    report("status", 40'(status), 40'(b.status));
                if (data[31:0] != b.entry_value)
                    report("entry_value", 40'(data[31:0]), 40'(b.entry_value));
                if (data[36:32] != b.entry_count)
                    report("entry_count", 40'(data[36:32]), 40'(b.entry_count));
                if (data[39:37] != 3'b000)
                    report("tdata padding", 40'(data[39:37]), '0);
                if (last != b.last)
                    report("last", 40'(last), 40'(b.last));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    list_scoreboard sb = new();

    // Shared pacing controls: quiet turns off random idling on both sides,
    // rx_hold asks the receiver for one long hold-off.
    bit quiet   = 1'b0;
    bit rx_hold = 1'b0;
    int sent    = 0;

    sorted_list_engine_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Draws an idle step with a chance of 22 in a hundred, unless a quiet stretch is running.
    function automatic bit gap_roll();
        return !quiet && ($urandom_range(0, 99) < 22);
    endfunction

    // Values lean toward the extremes and a narrow band around zero so that
    // ties and duplicates are common.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7)) inside
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3, 4: return 32'($urandom_range(0, 8)) - 32'd4;
            default: return $urandom();
        endcase
    endfunction

    // Mostly a real entry of the list, sometimes anything at all.
    function automatic logic signed [31:0] pick_present();
        if (sb.fill > 0 && $urandom_range(0, 99) < 85)
            return sb.cells[$urandom_range(0, sb.fill - 1)];
        return pick_value();
    endfunction

    // Mostly a position inside the list, sometimes anywhere in the field.
    function automatic logic [4:0] pick_position();
        if ($urandom_range(0, 99) < 70)
            return 5'($urandom_range(0, sb.fill));
        return 5'($urandom_range(0, 31));
    endfunction

    // Offers one request beat and returns once it has been accepted. Starts
    // and ends at a falling edge; valid stays high into the next request when
    // no gap is drawn, so it is never dropped and raised in one step.
    task automatic send_req(input logic [1:0] req, input logic signed [31:0] val,
                            input logic [4:0] pos);
        while (gap_roll())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, pos, val};
        s_tuser  <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(req, val, pos);
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.due.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            send_req(REQ_SORT, pick_value(), 5'($urandom()));
        else if (roll < 55)
            send_req(REQ_POS, pick_value(), pick_position());
        else if (roll < 80)
            send_req(REQ_DEL, pick_present(), 5'($urandom()));
        else
            send_req(REQ_LIST, pick_value(), 5'($urandom()));
    endtask

    // Inserts until the list is full, then pushes past it and reads it out.
    task automatic fill_phase();
        while (sb.fill < DEPTH)
        begin
            if ($urandom_range(0, 1))
                send_req(REQ_SORT, pick_value(), 5'($urandom()));
            else
                send_req(REQ_POS, pick_value(), pick_position());
        end
        send_req(REQ_SORT, pick_value(), 5'($urandom()));
        send_req(REQ_POS, pick_value(), 5'($urandom()));
        send_req(REQ_LIST, pick_value(), 5'($urandom()));
    endtask

    // Deletes until the list is empty, with some misses and list reads mixed in, then
    // exercises the empty-list answers.
    task automatic drain_phase();
        while (sb.fill > 0)
        begin
            if ($urandom_range(0, 99) < 15)
                send_req(REQ_DEL, pick_value(), 5'($urandom()));
            else if ($urandom_range(0, 99) < 10)
                send_req(REQ_LIST, pick_value(), 5'($urandom()));
            else
                send_req(REQ_DEL, sb.cells[$urandom_range(0, sb.fill - 1)], 5'($urandom()));
        end
        send_req(REQ_DEL, pick_value(), 5'($urandom()));
        send_req(REQ_LIST, pick_value(), 5'($urandom()));
    endtask

    // Receiver: random back-pressure, one long hold-off on request.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                rx_hold = 1'b0;
            end
            else
            begin
                m_tready <= !gap_roll();
            end
        end
    end

    // Every output beat taken is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tuser, m_tdata, m_tlast);
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    initial
    begin
        int dead;
        dead = 0;
        while (dead < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                dead = 0;
            else
                dead++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        int phase;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty-list answers, extremes, ties at the head and
        // in the middle, head insert, insert past the end, misses.
        send_req(REQ_LIST, 32'sd0, 5'd0);
        send_req(REQ_DEL, 32'sd7, 5'd0);
        send_req(REQ_SORT, 32'sd0, 5'd0);
        send_req(REQ_SORT, 32'sh7fffffff, 5'd31);
        send_req(REQ_SORT, 32'sh80000000, 5'd0);
        send_req(REQ_SORT, 32'sh80000000, 5'd16);
        send_req(REQ_SORT, 32'sd0, 5'd0);
        send_req(REQ_POS, 32'sd5, 5'd0);
        send_req(REQ_POS, -32'sd7, 5'd31);
        send_req(REQ_POS, 32'sd100, 5'd2);
        send_req(REQ_LIST, 32'sd0, 5'd0);
        send_req(REQ_DEL, 32'sd12345, 5'd0);
        send_req(REQ_DEL, 32'sd0, 5'd0);
        send_req(REQ_DEL, 32'sd5, 5'd0);
        send_req(REQ_DEL, -32'sd7, 5'd0);
        send_req(REQ_DEL, 32'sh7fffffff, 5'd0);
        send_req(REQ_LIST, 32'sd0, 5'd0);
        send_req(REQ_POS, -32'sd1, 5'd16);
        send_req(REQ_LIST, 32'shffffffff, 5'd31);
        wait_drained();

        // Random part in rounds of mixed traffic, a fill and a drain.
        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            case (phase % 4)
                0, 2:
                begin
                    // The second mixed round of the first pass runs with no
                    // idling at all on either side.
                    quiet = (phase == 2);
                    repeat (30) random_request();
                    quiet = 1'b0;
                end
                1:
                begin
                    // First fill: the receiver holds off, so the engine
                    // backs up and closes its input while requests wait.
                    if (phase == 1)
                        rx_hold = 1'b1;
                    fill_phase();
                end
                default:
                begin
                    drain_phase();
                    // Sender pauses until every pending beat is out.
                    wait_drained();
                end
            endcase
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
